>>> hw/rtl/sapq_pkg.sv
package sapq_pkg;

  localparam int unsigned ValueW = 32;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } opcode_t;

  typedef struct packed {
    opcode_t                   op;
    logic                      ins_en;
    logic                      rem_en;
    logic signed [ValueW-1:0]  value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/sapq_cell.sv
module sapq_cell (
  input  logic                                  clk,
  input  sapq_pkg::cell_ctrl_t                  ctrl,
  input  logic                                  occ,
  input  logic                                  prev_flag,
  input  logic signed [sapq_pkg::ValueW-1:0]    prev_value,
  input  logic signed [sapq_pkg::ValueW-1:0]    next_value,
  output logic                                  flag,
  output logic                                  eq,
  output logic signed [sapq_pkg::ValueW-1:0]    value,
  output logic signed [sapq_pkg::ValueW-1:0]    value_nxt
);
  import sapq_pkg::*;

  logic signed [ValueW-1:0] entry_r;
  logic                     ge;

  assign value = entry_r;
  assign ge    = ctrl.value >= entry_r;
  assign eq    = occ && (ctrl.value == entry_r);

  always_comb begin
    unique case (ctrl.op)
      OP_INSERT: flag = !occ || ge;
      OP_REMOVE: flag = occ && ge;
      default:   flag = 1'b0;
    endcase
  end

  always_comb begin
    value_nxt = entry_r;
    if (ctrl.ins_en) begin
      if (prev_flag) begin
        value_nxt = prev_value;
      end else if (flag) begin
        value_nxt = ctrl.value;
      end
    end else if (ctrl.rem_en && flag) begin
      value_nxt = next_value;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= value_nxt;
  end

endmodule

>>> hw/rtl/sorted_array_priority_queue_core.sv
// Sorted priority queue holding up to DEPTH signed 32-bit entries, largest first.
// Input channel in_*: one item per handshake carries an opcode (insert or remove)
// and a value. Insert places the value ahead of the first entry less than or equal
// to it; remove deletes the first entry equal to it.
// Result channel out_*: exactly one item per input item, carrying status
// (ok, full, empty, not found), the count after the operation and the head entry
// (0 when empty).
// Every cell of the row compares its entry against the value in parallel and
// shifts towards its neighbour, so an operation completes in the cycle it is
// accepted. The result is registered and appears on out_* in the cycle after
// acceptance; one item per cycle is sustained while out_tready stays high.
// When the receiver stalls, the result is held in the output register and
// in_tready falls until the result is taken.
// Reset (rst_n low, synchronous) empties the queue and drops any pending result;
// entry storage itself is not cleared, only entries below the count are read.
module sorted_array_priority_queue_core #(
  parameter int unsigned DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [0] opcode, [32:1] value, [39:33] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [5:2] count, [37:6] head_value, [39:38] zero
);
  import sapq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                     in_fire;
  opcode_t                  op;
  logic signed [ValueW-1:0] in_value;
  cell_ctrl_t               ctrl;
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic                     full;
  logic                     empty;
  logic                     found;
  status_t                  status;
  logic [31:0]              count_ext;
  logic signed [ValueW-1:0] head_nxt;
  logic                     out_valid_r;
  logic [39:0]              out_data_r;

  logic                     flag  [DEPTH];
  logic                     eq    [DEPTH];
  logic [DEPTH-1:0]         eq_v;
  logic signed [ValueW-1:0] value [DEPTH];
  logic signed [ValueW-1:0] vnxt  [DEPTH];

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign op        = opcode_t'(in_tdata[0]);
  assign in_value  = in_tdata[32:1];

  assign full  = count_r == CW'(DEPTH);
  assign empty = count_r == '0;
  assign found = |eq_v;

  assign ctrl.op     = op;
  assign ctrl.value  = in_value;
  assign ctrl.ins_en = in_fire && (op == OP_INSERT) && !full;
  assign ctrl.rem_en = in_fire && (op == OP_REMOVE) && !empty && found;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                     pf;
    logic signed [ValueW-1:0] pv;
    logic signed [ValueW-1:0] nv;

    if (i == 0) begin : g_first
      assign pf = 1'b0;
      assign pv = value[i];
    end else begin : g_mid
      assign pf = flag[i-1];
      assign pv = value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign nv = value[i];
    end else begin : g_inner
      assign nv = value[i+1];
    end

    assign eq_v[i] = eq[i];

    sapq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (CW'(i) < count_r),
      .prev_flag  (pf),
      .prev_value (pv),
      .next_value (nv),
      .flag       (flag[i]),
      .eq         (eq[i]),
      .value      (value[i]),
      .value_nxt  (vnxt[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins_en) begin
      count_nxt = count_r + CW'(1);
    end else if (ctrl.rem_en) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    unique case (op)
      OP_INSERT: status = full ? ST_FULL : ST_OK;
      OP_REMOVE: begin
        priority if (empty) begin
          status = ST_EMPTY;
        end else if (!found) begin
          status = ST_NOT_FOUND;
        end else begin
          status = ST_OK;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign count_ext = 32'(count_nxt);
  assign head_nxt  = (count_nxt == '0) ? '0 : vnxt[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= {2'b00, head_nxt, count_ext[3:0], status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count beyond depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.ins_en |=> count_r == $past(count_r) + CW'(1))
    else $error("accepted insert did not grow the queue");

  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_head_order: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CW'(2) |-> value[0] >= value[1])
    else $error("head entries out of order");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

import sapq_pkg::*;

typedef struct {
  status_t                   status;
  logic [3:0]                count;
  logic signed [ValueW-1:0]  head;
} pq_reply_t;

class pq_tracker #(parameter int Depth = 8);
  logic signed [ValueW-1:0] cells [Depth];
  int unsigned              fill;
  pq_reply_t                pending [$];
  int                       errors;

  function new();
    fill   = 0;
    errors = 0;
  endfunction

  function void note_request(opcode_t op, logic signed [ValueW-1:0] v);
    pq_reply_t   r;
    int unsigned pos;
    bit          hit;
    r.status = ST_OK;
    hit = 0;
    pos = fill;
    if (op == OP_INSERT) begin
      if (fill >= Depth) begin
        r.status = ST_FULL;
      end else begin
        for (int k = 0; k < fill; k++) begin
          if (!hit && v >= cells[k]) begin
            pos = k;
            hit = 1;
          end
        end
        for (int k = fill; k > pos; k--) cells[k] = cells[k-1];
        cells[pos] = v;
        fill++;
      end
    end else begin
      if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        for (int k = 0; k < fill; k++) begin
          if (!hit && cells[k] == v) begin
            pos = k;
            hit = 1;
          end
        end
        if (!hit) begin
          r.status = ST_NOT_FOUND;
        end else begin
          for (int k = pos; k + 1 < fill; k++) cells[k] = cells[k+1];
          fill--;
        end
      end
    end
    r.count = fill[3:0];
    r.head  = (fill > 0) ? cells[0] : '0;
    pending.push_back(r);
  endfunction

  function void check_reply(logic [39:0] d);
    pq_reply_t exp_r;
    if (pending.size() == 0) begin
      $error("result item with no expectation: tdata %h", d);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (d[1:0] !== exp_r.status) begin
      $error("status: expected %0d, actual %0d", exp_r.status, d[1:0]);
      errors++;
    end
    if (d[5:2] !== exp_r.count) begin
      $error("count: expected %0d, actual %0d", exp_r.count, d[5:2]);
      errors++;
    end
    if (d[37:6] !== exp_r.head) begin
      $error("head_value: expected %0d, actual %0d", exp_r.head, $signed(d[37:6]));
      errors++;
    end
  endfunction
endclass

module testbench;
  localparam int QueueDepth = 8;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;

  int unsigned in_gap_max;
  int unsigned out_gap_max;
  int unsigned insert_pct;

  pq_tracker #(QueueDepth) sb;

  sorted_array_priority_queue_core #(.DEPTH(QueueDepth)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("sorted_array_priority_queue_core verification failed");
    $finish;
  end

  task automatic send_item(opcode_t op, logic signed [ValueW-1:0] v);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, v, op};
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, v);
  endtask

  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(0, 10) - 5;
    if (r < 75 && sb.fill > 0) return sb.cells[$urandom_range(0, sb.fill - 1)];
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0: return 32'sh7fff_ffff;
        1: return 32'sh8000_0000;
        2: return 32'sh0000_0000;
        3: return -32'sd1;
        default: return 32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int unsigned stall;
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = $urandom_range(0, out_gap_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      sb.check_reply(out_tdata);
    end
  end

  initial begin
    opcode_t op;
    sb          = new();
    in_gap_max  = 18;
    out_gap_max = 18;
    insert_pct  = 50;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_REMOVE, 32'sd5);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, 32'sh7fff_ffff);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_INSERT, -32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, 32'sd1);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, 32'sd3);
    send_item(OP_REMOVE, 32'sd42);
    send_item(OP_REMOVE, 32'sd1);
    send_item(OP_REMOVE, 32'sh7fff_ffff);
    send_item(OP_REMOVE, 32'sh8000_0000);
    send_item(OP_REMOVE, 32'sd0);
    send_item(OP_REMOVE, 32'sd0);
    send_item(OP_REMOVE, -32'sd1);
    send_item(OP_REMOVE, 32'sd1);
    send_item(OP_REMOVE, 32'sd1);
    send_item(OP_REMOVE, 32'sd0);
    send_item(OP_INSERT, $urandom);
    send_item(OP_REMOVE, $urandom);

    for (int i = 0; i < 1350; i++) begin
      if (i % 48 == 0) begin
        in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 18;
        out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 18;
        case ($urandom_range(0, 2))
          0: insert_pct = 20;
          1: insert_pct = 50;
          default: insert_pct = 80;
        endcase
      end
      op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      send_item(op, pick_value());
    end
    in_tvalid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.errors == 0) begin
      $display("sorted_array_priority_queue_core verification clean");
    end else begin
      $display("sorted_array_priority_queue_core verification failed");
    end
    $finish;
  end
endmodule

>>> sorted_array_priority_queue_core.f
hw/rtl/sapq_pkg.sv
hw/rtl/sapq_cell.sv
hw/rtl/sorted_array_priority_queue_core.sv
bench/testbench.sv
